/* rtl/decimal_digit_trie_set_core_defines.svh */
// Assertion macros shared by the checker of the decimal digit trie set.
`ifndef DECIMAL_DIGIT_TRIE_SET_CORE_DEFINES_SVH
`define DECIMAL_DIGIT_TRIE_SET_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DTRIE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("decimal digit trie set assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define DTRIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("decimal digit trie set assertion failed");

`endif

/* rtl/dtrie_pkg.sv */
// Package with the types, codes and constants of the decimal digit trie set.
`default_nettype none
package dtrie_pkg;
    localparam int OP_W       = 2;
    localparam int KEY_W      = 31;
    localparam int RADIX      = 10;
    localparam int DIGIT_W    = 4;
    localparam int KEY_DIGITS = 10;
    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(KEY_DIGITS + 1);
    localparam int DIG_IDX_W  = $clog2(KEY_DIGITS);

    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;
    localparam int PROD_W      = KEY_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef logic [DIGIT_W-1:0] t_digit;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [CNT_W-1:0]           cnt;
        logic                       too_long;
        t_digit [KEY_DIGITS-1:0]    digits;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;
endpackage
`default_nettype wire

/* rtl/dtrie_ifs.sv */
// Handshake interfaces for the operation and result channels of the trie set.
`default_nettype none
interface dtrie_in_if import dtrie_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    modport source(output valid, output op, output key, input ready);
    modport sink(input valid, input op, input key, output ready);
endinterface

interface dtrie_out_if ();
    logic valid;
    logic ready;
    logic found;
    logic status;
    modport source(output valid, output found, output status, input ready);
    modport sink(input valid, input found, input status, output ready);
endinterface
`default_nettype wire

/* rtl/dtrie_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none
module dtrie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* rtl/dtrie_front.sv */
// Front end: accepts operation beats and splits the key into decimal digits.
`default_nettype none
module dtrie_front import dtrie_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    dtrie_in_if.sink    i_in,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  wire t_qstat i_qstat
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [OP_W-1:0]         r_op;
    logic [KEY_W-1:0]        r_val;
    logic [PROD_W-1:0]       r_prod;
    logic [CNT_W-1:0]        r_cnt;
    t_digit [KEY_DIGITS-1:0] r_digits;
    logic [QUO_W-1:0]        w_quo;
    t_digit                  w_q10_lo;
    t_digit                  w_rem;
    logic                    w_accept;

    assign i_in.ready = i_en && (r_state == F_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_quo    = r_prod[PROD_W-1:RECIP_SHIFT];
    assign w_q10_lo = {w_quo[0], 3'b000} + {w_quo[2:0], 1'b0};
    assign w_rem    = r_val[DIGIT_W-1:0] - w_q10_lo;

    assign o_push          = (r_state == F_PUSH) && !i_qstat.full;
    assign o_cmd.op        = r_op;
    assign o_cmd.cnt       = r_cnt;
    assign o_cmd.too_long  = int'(r_cnt) > MAX_DIGITS;
    assign o_cmd.digits    = r_digits;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    if (i_in.op == OP_ADD || i_in.op == OP_SEARCH) begin
                        n_state = F_MUL;
                    end else begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_MUL: begin
                n_state = F_DIV;
            end
            F_DIV: begin
                n_state = (w_quo == '0) ? F_PUSH : F_MUL;
            end
            F_PUSH: begin
                if (o_push) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in.op;
            r_val <= i_in.key;
            r_cnt <= '0;
        end else if (r_state == F_MUL) begin
            r_prod <= PROD_W'(r_val) * PROD_W'(RECIP);
        end else if (r_state == F_DIV) begin
            r_digits[r_cnt[DIG_IDX_W-1:0]] <= w_rem;
            r_cnt                          <= r_cnt + CNT_W'(1);
            r_val                          <= KEY_W'(w_quo);
        end
    end
endmodule
`default_nettype wire

/* rtl/dtrie_cmdq.sv */
// Short command queue between the digit splitter and the trie walker.
`default_nettype none
module dtrie_cmdq import dtrie_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_qstat    o_qstat
);
    localparam logic [CMDQ_PTR_W-1:0] PTR_LAST = CMDQ_PTR_W'(CMDQ_DEPTH - 1);
    localparam logic [CMDQ_CNT_W-1:0] CNT_FULL = CMDQ_CNT_W'(CMDQ_DEPTH);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;

    assign o_cmd         = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == CNT_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + CMDQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + CMDQ_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CMDQ_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CMDQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

/* rtl/dtrie_back.sv */
// Back end: walks the node pool one digit at a time and returns the result beat.
`default_nettype none
module dtrie_back import dtrie_pkg::*; #(
    parameter int POOL_NODES = 1024
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cmd   i_cmd,
    input  wire t_qstat i_qstat,
    output logic        o_pop,
    output logic        o_ready_en,
    dtrie_out_if.source o_out
);
    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int USED_W  = NODE_W + 1;
    localparam int LINKS_W = RADIX * NODE_W;
    localparam int ROW_W   = LINKS_W + 1;
    localparam logic [USED_W-1:0] POOL_LIM = USED_W'(POOL_NODES);

    localparam logic [2:0] B_INIT = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_READ = 3'd2;
    localparam logic [2:0] B_EVAL = 3'd3;
    localparam logic [2:0] B_ZERO = 3'd4;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [NODE_W-1:0]            r_cur;
    logic [NODE_W-1:0]            n_cur;
    logic [USED_W-1:0]            r_used;
    logic [USED_W-1:0]            n_used;
    logic [CNT_W-1:0]             r_left;
    logic [CNT_W-1:0]             n_left;
    logic [OP_W-1:0]              r_op;
    logic [OP_W-1:0]              n_op;
    t_digit [KEY_DIGITS-1:0]      r_digits;
    t_digit [KEY_DIGITS-1:0]      n_digits;
    logic                         r_o_valid;
    logic                         n_o_valid;
    logic                         r_found;
    logic                         n_found;
    logic                         r_status;
    logic                         n_status;

    logic [ROW_W-1:0]             w_row;
    logic [RADIX-1:0][NODE_W-1:0] w_links;
    logic [RADIX-1:0][NODE_W-1:0] w_new_links;
    logic                         w_mark;
    logic [DIG_IDX_W-1:0]         w_idx;
    t_digit                       w_digit;
    logic [NODE_W-1:0]            w_nxt;
    logic                         w_we;
    logic [NODE_W-1:0]            w_addr;
    logic [ROW_W-1:0]             w_wdata;

    dtrie_ram #(
        .WIDTH(ROW_W),
        .DEPTH(POOL_NODES)
    ) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_row)
    );

    assign w_links    = w_row[LINKS_W-1:0];
    assign w_mark     = w_row[ROW_W-1];
    assign w_idx      = DIG_IDX_W'(r_left - CNT_W'(1));
    assign w_digit    = r_digits[w_idx];
    assign w_nxt      = w_links[w_digit];
    assign o_ready_en = (r_state != B_INIT);

    assign o_out.valid  = r_o_valid;
    assign o_out.found  = r_found;
    assign o_out.status = r_status;

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_used    = r_used;
        n_left    = r_left;
        n_op      = r_op;
        n_digits  = r_digits;
        n_o_valid = r_o_valid;
        n_found   = r_found;
        n_status  = r_status;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_addr    = r_cur;
        w_wdata   = '0;

        w_new_links          = w_links;
        w_new_links[w_digit] = r_used[NODE_W-1:0];

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            B_INIT: begin
                w_we    = 1'b1;
                w_addr  = '0;
                n_state = B_IDLE;
            end
            B_IDLE: begin
                w_addr = '0;
                if (!i_qstat.empty && !r_o_valid) begin
                    o_pop    = 1'b1;
                    n_op     = i_cmd.op;
                    n_digits = i_cmd.digits;
                    n_left   = i_cmd.cnt;
                    n_cur    = '0;
                    n_found  = 1'b0;
                    n_status = 1'b0;
                    unique case (i_cmd.op) inside
                        OP_ADD, OP_SEARCH: begin
                            if (i_cmd.too_long) begin
                                n_o_valid = 1'b1;
                            end else begin
                                n_state = B_READ;
                            end
                        end
                        OP_CLEAR: begin
                            w_we      = 1'b1;
                            n_used    = USED_W'(1);
                            n_o_valid = 1'b1;
                        end
                        default: begin
                            n_o_valid = 1'b1;
                        end
                    endcase
                end
            end
            B_READ: begin
                n_state = B_EVAL;
            end
            B_EVAL: begin
                if (r_left == '0) begin
                    if (r_op == OP_SEARCH) begin
                        n_found = w_mark;
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = {1'b1, w_links};
                    end
                    n_o_valid = 1'b1;
                    n_state   = B_IDLE;
                end else if (w_nxt != '0) begin
                    n_cur   = w_nxt;
                    n_left  = r_left - CNT_W'(1);
                    n_state = B_READ;
                end else if (r_op == OP_SEARCH) begin
                    n_o_valid = 1'b1;
                    n_state   = B_IDLE;
                end else if (r_used >= POOL_LIM) begin
                    n_status  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = B_IDLE;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = {w_mark, w_new_links};
                    n_cur   = r_used[NODE_W-1:0];
                    n_used  = r_used + USED_W'(1);
                    n_left  = r_left - CNT_W'(1);
                    n_state = B_ZERO;
                end
            end
            B_ZERO: begin
                w_we    = 1'b1;
                n_state = B_READ;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_INIT;
            r_cur     <= '0;
            r_used    <= USED_W'(1);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_used    <= n_used;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_op     <= n_op;
        r_digits <= n_digits;
        r_found  <= n_found;
        r_status <= n_status;
    end
endmodule
`default_nettype wire

/* rtl/decimal_digit_trie_set_core.sv */
// Top level of the decimal digit trie set: digit splitter, command queue, trie walker.
// Front: takes a beat, splits an add or search key in a MUL and DIV state per digit, pushes.
// Back: pops, READ and EVAL states per trie level and end node, a ZERO state per node taken.
// The back's single-port node RAM read-modify-write loop sets the pace; the front can take
// and split the next key while the back still walks the last one.
// After reset the root row is cleared in the init state, during which no operation beat is taken.
`default_nettype none
module decimal_digit_trie_set_core import dtrie_pkg::*; #(
    parameter int POOL_NODES = 1024
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dtrie_in_if.sink    i_in,
    dtrie_out_if.source o_out
);
    logic   w_push;
    logic   w_pop;
    logic   w_ready_en;
    t_cmd   w_cmd_in;
    t_cmd   w_cmd_out;
    t_qstat w_qstat;

    dtrie_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_ready_en),
        .i_in   (i_in),
        .o_push (w_push),
        .o_cmd  (w_cmd_in),
        .i_qstat(w_qstat)
    );

    dtrie_cmdq u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_cmd_in),
        .i_pop  (w_pop),
        .o_cmd  (w_cmd_out),
        .o_qstat(w_qstat)
    );

    dtrie_back #(
        .POOL_NODES(POOL_NODES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd_out),
        .i_qstat   (w_qstat),
        .o_pop     (w_pop),
        .o_ready_en(w_ready_en),
        .o_out     (o_out)
    );
endmodule
`default_nettype wire

/* rtl/dtrie_checker.sv */
// Port-level checker for the decimal digit trie set and its bind to the top level.
`default_nettype none
`include "decimal_digit_trie_set_core_defines.svh"
module dtrie_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_found,
    input wire logic i_status
);
    localparam logic [2:0] PEND_MAX = 3'd4;

    logic [2:0] r_pending;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_out_wait;

    assign w_in_acc   = i_in_valid && i_in_ready;
    assign w_out_acc  = i_out_valid && i_out_ready;
    assign w_out_wait = i_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {2'b00, w_in_acc} - {2'b00, w_out_acc};
        end
    end

    `DTRIE_ASSERT_NEXT(a_out_hold, w_out_wait, i_out_valid && $stable({i_found, i_status}))
    `DTRIE_ASSERT_SAME(a_full_not_found, i_out_valid, !(i_found && i_status))
    `DTRIE_ASSERT_SAME(a_no_extra_beat, i_out_valid, r_pending != 3'd0)
    `DTRIE_ASSERT_SAME(a_pending_bound, 1'b1, r_pending <= PEND_MAX)
endmodule

bind decimal_digit_trie_set_core dtrie_checker u_dtrie_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_found    (o_out.found),
    .i_status   (o_out.status)
);
`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the decimal digit trie set core: probe table and random traffic.
`default_nettype none
module testbench;
    import dtrie_pkg::*;

    localparam int POOL_NODES  = 1024;
    localparam int DIGIT_BUF   = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 300000;
    localparam longint unsigned KEY_MAX = 64'd2147483647;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic found;
        logic status;
    } t_answer;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic             typed;
        logic             found;
        logic             status;
    } t_probe_row;

    logic clk = 1'b0;
    logic rst_n;

    dtrie_in_if  in_if ();
    dtrie_out_if out_if ();

    decimal_digit_trie_set_core #(
        .POOL_NODES(POOL_NODES)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #5 clk = ~clk;

    int unsigned trie_next [POOL_NODES][RADIX];
    bit          trie_mark [POOL_NODES];
    int unsigned trie_used;

    t_answer          awaited_answers [$];
    logic [KEY_W-1:0] known_keys [$];
    int               errors = 0;
    int               cycles = 0;
    bit               send_idle = 1'b1;
    bit               recv_idle = 1'b1;
    bit               hold_req = 1'b0;

    t_probe_row probes [24] = '{
        '{OP_SEARCH, 31'd0,          1'b1, 1'b0, 1'b0},
        '{OP_ADD,    31'd0,          1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd0,          1'b1, 1'b1, 1'b0},
        '{OP_ADD,    31'd2147483647, 1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd2147483647, 1'b1, 1'b1, 1'b0},
        '{OP_SEARCH, 31'd2147483646, 1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd214748364,  1'b1, 1'b0, 1'b0},
        '{OP_ADD,    31'd214748364,  1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd214748364,  1'b1, 1'b1, 1'b0},
        '{OP_ADD,    31'd2147483647, 1'b1, 1'b0, 1'b0},
        '{OP_UNUSED, 31'd2147483647, 1'b1, 1'b0, 1'b0},
        '{OP_UNUSED, 31'd0,          1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd7,          1'b1, 1'b0, 1'b0},
        '{OP_ADD,    31'd9,          1'b1, 1'b0, 1'b0},
        '{OP_ADD,    31'd10,         1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd1,          1'b0, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd10,         1'b1, 1'b1, 1'b0},
        '{OP_CLEAR,  31'd1234,       1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd2147483647, 1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd0,          1'b1, 1'b0, 1'b0},
        '{OP_ADD,    31'd1000000000, 1'b1, 1'b0, 1'b0},
        '{OP_SEARCH, 31'd1000000000, 1'b1, 1'b1, 1'b0},
        '{OP_SEARCH, 31'd100000000,  1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,  31'd0,          1'b1, 1'b0, 1'b0}
    };

    function automatic void trie_clear_node(input int unsigned node);
        for (int d = 0; d < RADIX; d++) trie_next[node][d] = 0;
        trie_mark[node] = 1'b0;
    endfunction

    function automatic void trie_reset();
        for (int n = 0; n < POOL_NODES; n++) trie_clear_node(n);
        trie_used = 1;
    endfunction

    function automatic void trie_apply(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                       output logic found, output logic full);
        logic [DIGIT_W-1:0] rev [DIGIT_BUF];
        longint unsigned k;
        int n;
        int unsigned cur;
        int unsigned nxt;
        bit stop;
        found = 1'b0;
        full = 1'b0;
        k = 64'(key);
        n = 0;
        cur = 0;
        stop = 1'b0;
        if (op == OP_CLEAR) begin
            trie_clear_node(0);
            trie_used = 1;
        end else if (op == OP_ADD || op == OP_SEARCH) begin
            do begin
                rev[n] = DIGIT_W'(k % 10);
                k = k / 10;
                n++;
            end while (k != 0 && n < DIGIT_BUF);
            if (n <= MAX_DIGITS) begin
                for (int i = n - 1; i >= 0 && !stop; i--) begin
                    nxt = trie_next[cur][rev[i]];
                    if (op == OP_ADD) begin
                        if (nxt == 0) begin
                            if (trie_used >= POOL_NODES) begin
                                full = 1'b1;
                                stop = 1'b1;
                            end else begin
                                nxt = trie_used;
                                trie_used++;
                                trie_clear_node(nxt);
                                trie_next[cur][rev[i]] = nxt;
                            end
                        end
                    end else if (nxt == 0 || nxt >= POOL_NODES) begin
                        stop = 1'b1;
                    end
                    if (!stop) cur = nxt;
                end
                if (!stop) begin
                    if (op == OP_ADD) trie_mark[cur] = 1'b1;
                    else found = trie_mark[cur];
                end
            end
        end
    endfunction

    function automatic logic [KEY_W-1:0] key_pick();
        int sel;
        int len;
        longint unsigned m;
        longint unsigned k;
        longint unsigned base;
        sel = $urandom_range(0, 99);
        m = 1;
        if (sel < 35 || known_keys.size() == 0) begin
            k = 64'($urandom() & 32'h7FFF_FFFF);
        end else if (sel < 60) begin
            len = $urandom_range(1, 9);
            repeat (len) m = m * 10;
            k = $urandom() % m;
        end else if (sel < 85) begin
            base = 64'(known_keys[$urandom_range(0, known_keys.size() - 1)]);
            len = $urandom_range(1, 4);
            repeat (len) m = m * 10;
            k = base - (base % m) + ($urandom() % m);
            if (k > KEY_MAX) k = base;
        end else begin
            k = 64'(known_keys[$urandom_range(0, known_keys.size() - 1)]);
        end
        return k[KEY_W-1:0];
    endfunction

    task automatic offer_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic typed, input logic tf, input logic ts);
        int gap;
        logic pf;
        logic ps;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.op <= op;
        in_if.key <= key;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        trie_apply(op, key, pf, ps);
        if (typed) awaited_answers.push_back({tf, ts});
        else awaited_answers.push_back({pf, ps});
        if (op == OP_ADD) begin
            known_keys.push_back(key);
            if (known_keys.size() > 256) void'(known_keys.pop_front());
        end
    endtask

    task automatic await_drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (awaited_answers.size() != 0) @(posedge clk);
    endtask

    task automatic random_beat(input int add_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct) offer_beat(OP_ADD, key_pick(), 1'b0, 1'b0, 1'b0);
        else if (r < 94) offer_beat(OP_SEARCH, key_pick(), 1'b0, 1'b0, 1'b0);
        else if (r < 97) offer_beat(OP_UNUSED, key_pick(), 1'b0, 1'b0, 1'b0);
        else offer_beat(OP_CLEAR, key_pick(), 1'b0, 1'b0, 1'b0);
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int gap;
        t_answer want;
        out_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = recv_idle ? $urandom_range(0, 9) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
            if (awaited_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, found %0b status %0b", $time,
                         out_if.found, out_if.status);
            end else begin
                want = awaited_answers.pop_front();
                if (out_if.found !== want.found) begin
                    errors++;
                    $display("%0t: found mismatch, expected %0b actual %0b", $time,
                             want.found, out_if.found);
                end
                if (out_if.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0b actual %0b", $time,
                             want.status, out_if.status);
                end
            end
        end
    end

    initial begin
        rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.op <= OP_ADD;
        in_if.key <= '0;
        trie_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        foreach (probes[i]) begin
            offer_beat(probes[i].op, probes[i].key, probes[i].typed, probes[i].found,
                       probes[i].status);
        end
        await_drain();
        for (int p = 0; p < 8; p++) begin
            send_idle = !(p == 1 || p == 2 || p == 5);
            recv_idle = !(p == 2 || p == 5);
            if (p == 1) hold_req = 1'b1;
            if (p == 4) begin
                // Fill the node pool, then keep adding and searching with mixed random beats, and end with a clear.
                while (trie_used < POOL_NODES) begin
                    if ($urandom_range(0, 99) < 88) begin
                        offer_beat(OP_ADD, KEY_W'($urandom()), 1'b0, 1'b0, 1'b0);
                    end else begin
                        offer_beat(OP_SEARCH, key_pick(), 1'b0, 1'b0, 1'b0);
                    end
                end
                repeat (30) random_beat(50);
                offer_beat(OP_CLEAR, '0, 1'b1, 1'b0, 1'b0);
            end else begin
                repeat (55) random_beat(48);
                if (p == 3 || p == 6) offer_beat(OP_CLEAR, key_pick(), 1'b1, 1'b0, 1'b0);
            end
            await_drain();
        end
        repeat (60) @(posedge clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
